// ===== hw/rtl/fhn_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the hopping mixer.
package fhn_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int PHASE_BITS    = 32;
	localparam int LUT_ADDR_BITS = 10;
	localparam int MAX_CHANNELS  = 256;
	localparam int MAX_FRAME     = 4096;
	localparam int HOP_DEPTH     = 2 * MAX_CHANNELS;
	localparam int HOP_BITS      = 9;
	localparam int CHAN_BITS     = 8;
	localparam int POS_BITS      = 12;
	localparam int QTR_LEN       = 256;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QLEVEL_BITS   = 3;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		REG_SAMPLES_PER_HOP  = 3'd0,
		REG_CHANNEL_COUNT    = 3'd1,
		REG_CARRIER_INC      = 3'd2,
		REG_CHANNEL_STEP_INC = 3'd3,
		REG_START_HOP        = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [12:0]        samples_per_hop;
		logic [8:0]         channel_count;
		logic signed [31:0] carrier_inc;
		logic [30:0]        channel_step_inc;
		logic [8:0]         start_hop;
	} cfg_t;

	// One sample on its way from the front end to the mixer.
	typedef struct packed {
		logic                   start;
		logic                   last;
		logic [CHAN_BITS-1:0]   channel;
		logic signed [15:0]     sample_i;
		logic signed [15:0]     sample_q;
	} job_t;

	typedef struct packed {
		logic                busy;
		logic [HOP_BITS-1:0] hop;
		logic [HOP_BITS:0]   len;
	} front_status_t;

	// Clamp the channel count to [1, MAX_CHANNELS].
	function automatic logic [8:0] chan_eff(logic [8:0] c);
		logic [8:0] r;
		r = c;
		if (c == 9'd0)
			r = 9'd1;
		else if (c > 9'(MAX_CHANNELS))
			r = 9'(MAX_CHANNELS);
		return r;
	endfunction

	// Clamp the frame length to [1, MAX_FRAME].
	function automatic logic [12:0] frame_eff(logic [12:0] f);
		logic [12:0] r;
		r = f;
		if (f == 13'd0)
			r = 13'd1;
		else if (f > 13'(MAX_FRAME))
			r = 13'(MAX_FRAME);
		return r;
	endfunction

	// Elaboration-time fixed-point helpers for the sine table.
	localparam longint unsigned LO32        = 64'h0000_0000_FFFF_FFFF;
	localparam longint unsigned HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
	localparam int              ANG_SHIFT   = LUT_ADDR_BITS - 2;

	function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
		longint unsigned a0, a1, b0, b1, p00, p01, p10, p11, mid, lo, hi;
		a0  = a & LO32;
		a1  = a >> 32;
		b0  = b & LO32;
		b1  = b >> 32;
		p00 = a0 * b0;
		p01 = a0 * b1;
		p10 = a1 * b0;
		p11 = a1 * b1;
		mid = (p00 >> 32) + (p01 & LO32) + (p10 & LO32);
		lo  = (p00 & LO32) | (mid << 32);
		hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
		return (hi << 2) | (lo >> 62);
	endfunction

	// Restoring long division for table building; the divisor stays below 2^12.
	function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
		longint unsigned quo, part;
		quo  = 64'd0;
		part = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			part = (part << 1) | ((num >> b) & 64'd1);
			quo  = quo << 1;
			if (part >= den) begin
				part = part - den;
				quo  = quo | 64'd1;
			end
		end
		return quo;
	endfunction

	function automatic logic [14:0] quarter_sine(longint unsigned x);
		longint unsigned x2, term, pos, neg, s, p, r, res;
		logic            done;
		x2   = mul_q62(x, x);
		term = x;
		pos  = x;
		neg  = 64'd0;
		done = 1'b0;
		for (int n = 1; n < 24; n++) begin
			if (!done) begin
				term = div_u64(mul_q62(term, x2), 64'((2 * n) * (2 * n + 1)));
				if (term == 64'd0)
					done = 1'b1;
				else if ((n & 1) == 1)
					neg = neg + term;
				else
					pos = pos + term;
			end
		end
		s = pos - neg;
		if (s > (64'd1 << 62))
			s = 64'd1 << 62;
		p   = 64'd32767 * (s >> 32);
		r   = 64'd32767 * (s & LO32);
		res = (p >> 30) + ((((p & 64'h3FFF_FFFF) << 32) + r + (64'd1 << 61)) >> 62);
		return res[14:0];
	endfunction

	function automatic longint unsigned table_angle(int k);
		longint unsigned kk;
		kk = longint'(k);
		return (HALF_PI_Q62 >> ANG_SHIFT) * kk +
		       (((HALF_PI_Q62 & ((64'd1 << ANG_SHIFT) - 64'd1)) * kk) >> ANG_SHIFT);
	endfunction

	typedef logic [QTR_LEN-1:0][14:0] qtab_t;

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int k = 0; k < QTR_LEN; k++)
			t[k] = quarter_sine(table_angle(k));
		return t;
	endfunction

	localparam qtab_t       QTAB     = build_qtab();
	localparam logic [14:0] SIN_PEAK = quarter_sine(table_angle(QTR_LEN));

	// Full-wave sine from the quarter table; addr is the top phase bits.
	function automatic logic signed [15:0] sin_lookup(logic [LUT_ADDR_BITS-1:0] addr);
		logic [1:0]  quad;
		logic [7:0]  rem;
		logic [8:0]  k;
		logic [14:0] mag;
		quad = addr[LUT_ADDR_BITS-1 -: 2];
		rem  = addr[7:0];
		k    = quad[0] ? (9'(QTR_LEN) - {1'b0, rem}) : {1'b0, rem};
		mag  = k[8] ? SIN_PEAK : QTAB[k[7:0]];
		return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

endpackage

// ===== hw/rtl/frequency_hopping_nco_mixer_top.sv =====
// Top level of the frequency-hopping NCO mixer: config registers, front end, queue, mixer.
//
// Frequency-hopping upconverter. Each input beat is either a hop table load (tuser low:
// table_index, table_value) or a complex sample (tuser high: sample_i, sample_q). Samples
// form frames of samples_per_hop beats; the first sample of a frame reads the channel at
// the current hop position, sets the phase increment to
// carrier_inc + (channel - floor(N/2)) * channel_step_inc and clears the phase, and the hop
// position then steps by one modulo 2*N. Every sample leaves as one mixed beat with tlast
// marking the end of a frame; loads produce no output. Throughput is one beat per clock in
// both directions while the output is ready and no hop position reduction is running. An
// accepted sample is registered in the front end for the hop table read, then held in the
// queue, then passes the stages of the mixer pipeline. After every configuration write the
// input stalls while a serial remainder unit reduces the hop position (or start_hop
// before the first frame) modulo the table length 2*N; write registers only while the
// block is idle. Hop table entries must be loaded before a frame uses them.
module frequency_hopping_nco_mixer_top import fhn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // table_index[8:0], table_value[16:9],
	                                   // sample_i[32:17], sample_q[48:33], zero fill
	input  logic        s_axis_tuser,  // op: 0 hop table load, 1 sample
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // out_i[15:0], out_q[31:16]
	output logic        m_axis_tlast   // last_in_frame
);

	cfg_t          cfg_q;
	front_status_t fr_status;
	job_t          push_job;
	job_t          pop_job;
	logic          q_push;
	logic          q_pop;
	logic          q_nonempty;
	logic [QLEVEL_BITS-1:0] q_level;
	logic signed [15:0] mix_i;
	logic signed [15:0] mix_q;

	// Register file; indexes outside the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_hop  <= 13'd64;
			cfg_q.channel_count    <= 9'd1;
			cfg_q.carrier_inc      <= '0;
			cfg_q.channel_step_inc <= '0;
			cfg_q.start_hop        <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_SAMPLES_PER_HOP:  cfg_q.samples_per_hop  <= cfg_wdata[12:0];
				REG_CHANNEL_COUNT:    cfg_q.channel_count    <= cfg_wdata[8:0];
				REG_CARRIER_INC:      cfg_q.carrier_inc      <= $signed(cfg_wdata);
				REG_CHANNEL_STEP_INC: cfg_q.channel_step_inc <= cfg_wdata[30:0];
				REG_START_HOP:        cfg_q.start_hop        <= cfg_wdata[8:0];
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	// Front end: hop table, frame counter, hop position.
	fhn_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cfg_we      (cfg_we),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.op          (s_axis_tuser),
		.table_index (s_axis_tdata[8:0]),
		.table_value (s_axis_tdata[16:9]),
		.sample_i    ($signed(s_axis_tdata[32:17])),
		.sample_q    ($signed(s_axis_tdata[48:33])),
		.queue_level (q_level),
		.push        (q_push),
		.job         (push_job),
		.status      (fr_status)
	);

	// Queue between front end and mixer; either side may stall on its own.
	fhn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_job),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_data  (pop_job),
		.level     (q_level)
	);

	// Mixer: increment, phase, sine/cosine, complex multiply, round and saturate.
	fhn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (q_nonempty),
		.job       (pop_job),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_i     (mix_i),
		.out_q     (mix_q),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {mix_q, mix_i};

	// Never push into a full queue unless a slot frees up in the same cycle.
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_level != QLEVEL_BITS'(QUEUE_DEPTH)) || q_pop)
		else $error("sample pushed into a full queue");

	// Hold the input off while the hop position is being reduced after a write.
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_axis_tready)
		else $error("input accepted during hop position reduction");

	// Outside the reduction the hop position lies inside the table.
	a_hop_range: assert property (@(posedge clk) disable iff (!arst_n)
		!fr_status.busy |-> ({1'b0, fr_status.hop} < fr_status.len))
		else $error("hop position beyond table length");

endmodule

// ===== hw/rtl/fhn_queue.sv =====
// Small FIFO that decouples the front end from the mixer pipeline.
module fhn_queue import fhn_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  job_t                   push_data,
	input  logic                   pop,
	output logic                   nonempty,
	output job_t                   pop_data,
	output logic [QLEVEL_BITS-1:0] level
);

	job_t       slots_q [QUEUE_DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [QLEVEL_BITS-1:0] level_q;

	assign nonempty = (level_q != '0);
	assign pop_data = slots_q[rd_ptr_q];
	assign level    = level_q;

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			case ({push, pop})
				2'b10:   level_q <= level_q + 3'd1;
				2'b01:   level_q <= level_q - 3'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/fhn_front.sv =====
// Front end: accepts beats, keeps the hop table and frame position, queues samples.
module fhn_front import fhn_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   cfg_we,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   op,
	input  logic [HOP_BITS-1:0]    table_index,
	input  logic [CHAN_BITS-1:0]   table_value,
	input  logic signed [15:0]     sample_i,
	input  logic signed [15:0]     sample_q,
	input  logic [QLEVEL_BITS-1:0] queue_level,
	output logic                   push,
	output job_t                   job,
	output front_status_t          status
);

	localparam logic [3:0]             RED_LOAD   = 4'(HOP_BITS + 1);
	localparam logic [QLEVEL_BITS-1:0] LEVEL_ROOM = QLEVEL_BITS'(QUEUE_DEPTH - 2);

	logic [CHAN_BITS-1:0] hop_table [HOP_DEPTH];

	logic [POS_BITS-1:0]  pos_q;
	logic                 started_q;
	logic [HOP_BITS-1:0]  hop_q;
	logic [3:0]           red_cnt_q;
	logic [HOP_BITS-1:0]  red_num_q;
	logic [HOP_BITS-1:0]  red_rem_q;

	logic                 valid_s1;
	logic                 start_s1;
	logic                 last_s1;
	logic [CHAN_BITS-1:0] chan_s1;
	logic signed [15:0]   i_s1;
	logic signed [15:0]   q_s1;

	logic [8:0]           n_eff;
	logic [HOP_BITS:0]    len;
	logic [12:0]          frame;
	logic                 busy;
	logic                 accept;
	logic                 is_sample;
	logic                 frame_start;
	logic [12:0]          pos_next;
	logic                 last;
	logic [HOP_BITS:0]    hop_inc;
	logic [HOP_BITS-1:0]  hop_wrap;
	logic [HOP_BITS:0]    rem_sh;
	logic [HOP_BITS-1:0]  rem_new;

	assign n_eff       = chan_eff(cfg.channel_count);
	assign len         = {n_eff, 1'b0};
	assign frame       = frame_eff(cfg.samples_per_hop);
	assign busy        = (red_cnt_q != 4'd0);
	assign in_ready    = !busy && (queue_level <= LEVEL_ROOM);
	assign accept      = in_valid && in_ready;
	assign is_sample   = (op == OP_SAMPLE);
	assign frame_start = (pos_q == '0);
	assign pos_next    = {1'b0, pos_q} + 13'd1;
	assign last        = (pos_next >= frame);
	assign hop_inc     = {1'b0, hop_q} + 10'd1;
	assign hop_wrap    = (hop_inc == len) ? '0 : hop_inc[HOP_BITS-1:0];

	// Serial remainder: one dividend bit per cycle.
	assign rem_sh  = {red_rem_q, red_num_q[HOP_BITS-1]};
	assign rem_new = (rem_sh >= len) ? HOP_BITS'(rem_sh - len) : rem_sh[HOP_BITS-1:0];

	always_ff @(posedge clk) begin
		if (accept && !is_sample)
			hop_table[table_index] <= table_value;
		if (accept)
			chan_s1 <= hop_table[hop_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1 <= frame_start;
			last_s1  <= last;
			i_s1     <= sample_i;
			q_s1     <= sample_q;
		end
		if (red_cnt_q == RED_LOAD) begin
			red_num_q <= started_q ? hop_q : cfg.start_hop;
			red_rem_q <= '0;
		end else if (busy) begin
			red_num_q <= red_num_q << 1;
			red_rem_q <= rem_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			started_q <= 1'b0;
			hop_q     <= '0;
			red_cnt_q <= 4'd0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept && is_sample;
			if (cfg_we) begin
				red_cnt_q <= RED_LOAD;
			end else if (busy) begin
				red_cnt_q <= red_cnt_q - 4'd1;
				if (red_cnt_q == 4'd1)
					hop_q <= rem_new;
			end
			if (accept && is_sample) begin
				pos_q <= last ? '0 : pos_next[POS_BITS-1:0];
				if (frame_start) begin
					started_q <= 1'b1;
					hop_q     <= hop_wrap;
				end
			end
		end
	end

	assign push         = valid_s1;
	assign job.start    = start_s1;
	assign job.last     = last_s1;
	assign job.channel  = chan_s1;
	assign job.sample_i = i_s1;
	assign job.sample_q = q_s1;

	assign status.busy = busy;
	assign status.hop  = hop_q;
	assign status.len  = len;

endmodule

// ===== hw/rtl/fhn_back.sv =====
// Mixer pipeline: channel increment, phase accumulator, sine lookup, complex multiply, round and saturate.
module fhn_back import fhn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               job_valid,
	input  job_t               job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_i,
	output logic signed [15:0] out_q,
	output logic               out_last
);

	function automatic logic signed [15:0] round_sat(logic signed [32:0] v);
		logic signed [33:0] t;
		logic signed [18:0] s;
		logic signed [15:0] r;
		t = 34'(v) + 34'sd16384;
		s = 19'(t >>> 15);
		if (s > 19'sd32767)
			r = 16'sh7FFF;
		else if (s < -19'sd32768)
			r = 16'sh8000;
		else
			r = s[15:0];
		return r;
	endfunction

	logic                      en;
	logic [8:0]                n_eff;
	logic [7:0]                half_n;
	logic signed [9:0]         diff;
	logic signed [41:0]        prod_full;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                      start_s1, start_s2;
	logic                      last_s1, last_s2, last_s3, last_s4, last_s5;
	logic signed [15:0]        i_s1, i_s2, i_s3, i_s4;
	logic signed [15:0]        q_s1, q_s2, q_s3, q_s4;
	logic [PHASE_BITS-1:0]     prod_s1;
	logic [PHASE_BITS-1:0]     inc_s2;
	logic [LUT_ADDR_BITS-1:0]  addr_s3;
	logic signed [15:0]        sin_s4, cos_s4;
	logic signed [31:0]        ic_s5, qs_s5, is_s5, qc_s5;

	logic [PHASE_BITS-1:0]     acc_q;
	logic [PHASE_BITS-1:0]     step_q;
	logic [PHASE_BITS-1:0]     phase_cur;
	logic                      out_valid_q;
	logic signed [15:0]        out_i_q, out_q_q;
	logic                      out_last_q;

	assign en        = !out_valid_q || out_ready;
	assign pop       = en && job_valid;
	assign n_eff     = chan_eff(cfg.channel_count);
	assign half_n    = n_eff[8:1];
	assign diff      = $signed({2'b00, job.channel}) - $signed({2'b00, half_n});
	assign prod_full = 42'(diff) * 42'($signed({1'b0, cfg.channel_step_inc}));
	assign phase_cur = start_s2 ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (en) begin
			start_s1 <= job.start;
			last_s1  <= job.last;
			i_s1     <= job.sample_i;
			q_s1     <= job.sample_q;
			prod_s1  <= prod_full[PHASE_BITS-1:0];

			start_s2 <= start_s1;
			last_s2  <= last_s1;
			i_s2     <= i_s1;
			q_s2     <= q_s1;
			inc_s2   <= PHASE_BITS'(cfg.carrier_inc) + prod_s1;

			last_s3  <= last_s2;
			i_s3     <= i_s2;
			q_s3     <= q_s2;
			addr_s3  <= phase_cur[PHASE_BITS-1 -: LUT_ADDR_BITS];

			last_s4  <= last_s3;
			i_s4     <= i_s3;
			q_s4     <= q_s3;
			sin_s4   <= sin_lookup(addr_s3);
			cos_s4   <= sin_lookup(addr_s3 + LUT_ADDR_BITS'(1 << (LUT_ADDR_BITS - 2)));

			last_s5  <= last_s4;
			ic_s5    <= i_s4 * cos_s4;
			qs_s5    <= q_s4 * sin_s4;
			is_s5    <= i_s4 * sin_s4;
			qc_s5    <= q_s4 * cos_s4;

			out_last_q <= last_s5;
			out_i_q    <= round_sat(33'(ic_s5) - 33'(qs_s5));
			out_q_q    <= round_sat(33'(is_s5) + 33'(qc_s5));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			step_q      <= '0;
		end else if (en) begin
			v_s1        <= job_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
			if (v_s2) begin
				acc_q <= phase_cur + (start_s2 ? inc_s2 : step_q);
				if (start_s2)
					step_q <= inc_s2;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_i     = out_i_q;
	assign out_q     = out_q_q;
	assign out_last  = out_last_q;

endmodule
